>>> hw/rtl/binary_to_decimal_ascii_assert.svh
// assertion macros for the binary to decimal ascii converter
// expects signals clk and arst_n in the module that uses them
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS
// plain property, checked at every clock edge out of reset
`define B2DA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication with the consequent checked in the cycle after the antecedent
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B2DA_ASSERT(lbl, prop, msg)
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/b2da_pkg.sv
// shared constants and controller/datapath interface types
// for the binary to decimal ascii converter; no dependencies
package b2da_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 10;

	// fixed field widths
	localparam int IN_W     = 32;
	localparam int CHAR_W   = 6;
	localparam int OUT_TD_W = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // take a new value, clear digits
		logic shift;  // one double-dabble step
		logic count;  // find the leading digit
		logic emit;   // put the current digit in the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic pos_zero;  // current digit is the least significant one
		logic out_busy;  // output register holds an item not taken this cycle
	} sts_t;

endpackage

>>> hw/rtl/b2da_ctrl.sv
// controller state machine of the binary to decimal ascii converter
// depends on b2da_pkg and binary_to_decimal_ascii_assert.svh
`include "binary_to_decimal_ascii_assert.svh"

module b2da_ctrl #(
	parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  b2da_pkg::sts_t sts,
	output b2da_pkg::cmd_t cmd
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_COUNT = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (cnt_q == CW'(1)) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					if (sts.pos_zero) state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= CW'(VALUE_BITS);
			else if (cmd.shift) cnt_q <= cnt_q - CW'(1);
		end
	end

	`B2DA_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.shift, cmd.count, cmd.emit}), "more than one datapath command")
	`B2DA_ASSERT_NEXT(a_load_shift, cmd.load, (state_q == ST_SHIFT) && (cnt_q == CW'(VALUE_BITS)), "load did not start conversion")
	`B2DA_ASSERT_NEXT(a_last_idle, cmd.emit && sts.pos_zero, state_q == ST_IDLE, "no return to idle after last digit")

endmodule

>>> hw/rtl/b2da_dpath.sv
// datapath of the binary to decimal ascii converter: binary shift register,
// bcd digit lanes with add-3 correction, digit pointer and output register
// depends on b2da_pkg and binary_to_decimal_ascii_assert.svh
`include "binary_to_decimal_ascii_assert.svh"

module b2da_dpath #(
	parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [b2da_pkg::IN_W-1:0]     value,
	input  b2da_pkg::cmd_t                cmd,
	output b2da_pkg::sts_t                sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [b2da_pkg::OUT_TD_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int PW = $clog2(MAX_DIGITS);

	logic [VALUE_BITS-1:0]     bin_q;
	logic [VALUE_BITS-1:0]     load_val;
	logic [3:0]                bcd_q [MAX_DIGITS];
	logic [3:0]                adj   [MAX_DIGITS];
	logic                      ovf_q;
	logic [PW-1:0]             pos_q;
	logic [PW-1:0]             lead;
	logic                      valid_q;
	logic [b2da_pkg::CHAR_W-1:0] char_q;
	logic                      last_q;

	generate
		if (VALUE_BITS <= b2da_pkg::IN_W) begin : g_narrow
			assign load_val = value[VALUE_BITS-1:0];
		end else begin : g_wide
			assign load_val = {{(VALUE_BITS - b2da_pkg::IN_W){1'b0}}, value};
		end
	endgenerate

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// highest nonzero digit, all digits when the number overflowed
	always_comb begin
		lead = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) lead = PW'(i);
		end
		if (ovf_q) lead = PW'(MAX_DIGITS - 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= load_val;
			for (int i = 0; i < MAX_DIGITS; i++) bcd_q[i] <= 4'd0;
		end else if (cmd.shift) begin
			bin_q    <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q[0] <= {adj[0][2:0], bin_q[VALUE_BITS-1]};
			for (int i = 1; i < MAX_DIGITS; i++) begin
				bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end
		if (cmd.emit) begin
			char_q <= b2da_pkg::ASCII_ZERO + {2'b00, bcd_q[pos_q]};
			last_q <= (pos_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) ovf_q <= 1'b0;
			else if (cmd.shift && adj[MAX_DIGITS-1][3]) ovf_q <= 1'b1;
			if (cmd.count) pos_q <= lead;
			else if (cmd.emit && pos_q != '0) pos_q <= pos_q - PW'(1);
			if (cmd.emit) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	assign sts.pos_zero = (pos_q == '0);
	assign sts.out_busy = valid_q && !m_tready;

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

	`B2DA_ASSERT(a_no_overrun, !(cmd.emit && valid_q && !m_tready), "digit overwrote a waiting item")
	`B2DA_ASSERT(a_digit_range, !valid_q || (char_q >= 6'd48 && char_q <= 6'd57), "digit char out of range")
	`B2DA_ASSERT_NEXT(a_load_clear, cmd.load, !ovf_q, "overflow flag survived load")

endmodule

>>> hw/rtl/binary_to_decimal_ascii.sv
// binary to decimal ascii converter, top level
// joins b2da_ctrl and b2da_dpath; depends on b2da_pkg
// usage:
//  - input channel s_*: one item is one unsigned value in s_tdata, taken at an
//    edge with s_tvalid and s_tready high; bits above VALUE_BITS are ignored
//  - output channel m_*: one item per decimal digit, most significant first,
//    leading zeros dropped; a value of zero gives the single digit '0';
//    m_tlast marks the least significant digit
//  - conversion is double dabble: VALUE_BITS shift steps over a row of
//    MAX_DIGITS bcd lanes, then a step to find the leading digit, then each
//    digit in turn into the output register
//  - the next item is accepted only after an item's last digit is loaded,
//    while that digit may still wait in the output register
//  - when the receiver stalls, digits hold in the output register and the
//    sequencer waits; nothing is dropped
//  - numbers needing more than MAX_DIGITS digits give their low MAX_DIGITS
//    digits, leading zeros included
//  - reset clears the sequencer and the output valid; no clearing pass
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,  // 4 to 64
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF   // 2 to 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [b2da_pkg::IN_W-1:0]     s_tdata,   // [31:0] value
	// output item, one per digit
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [b2da_pkg::OUT_TD_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic                          m_tlast    // last_digit
);

	b2da_pkg::cmd_t cmd;  // controller to datapath
	b2da_pkg::sts_t sts;  // datapath to controller

	// sequencer: idle, shift, count, emit
	b2da_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bcd lanes, digit pointer and output register
	b2da_dpath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/tb_binary_to_decimal_ascii.sv
// testbench for binary_to_decimal_ascii: streams unsigned values in, checks the decimal
// digit items that come out against an in-bench digit predictor
// depends on b2da_pkg and binary_to_decimal_ascii
module tb_binary_to_decimal_ascii;

	localparam int          VALUE_BITS  = b2da_pkg::VALUE_BITS_DEF;
	localparam int          MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEF;
	localparam int          IN_W        = b2da_pkg::IN_W;
	localparam int          CHAR_W      = b2da_pkg::CHAR_W;
	localparam int          OUT_TD_W    = b2da_pkg::OUT_TD_W;
	localparam logic [63:0] VALUE_MASK  = (64'd2 << (VALUE_BITS - 1)) - 64'd1;
	localparam logic [63:0] RADIX       = 64'd10;
	localparam int          TAIL_CYCLES = 64;    // extra wait after the last expected digit, with margin
	localparam int          HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int          QUIET_LIMIT = 2000;  // cycles with no item moving on either side
	localparam int          MAX_REPORTS = 10;

	// one expected output item
	typedef struct {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_item_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;      // [31:0] value
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TD_W-1:0] m_tdata;            // [5:0] digit_char, [7:6] zero
	logic                m_tlast;            // last_digit

	digit_item_t digits_due[$];              // digits still owed by the block, oldest first
	int          mismatch_count = 0;
	bit          gaps_on        = 1'b1;      // random idling on both sides
	int          hold_requests  = 0;         // bumped by the pressure test
	int          hold_served    = 0;
	int          hold_left      = 0;
	int          rx_gap_left    = 0;
	logic [31:0] pow10 [10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
		32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

	binary_to_decimal_ascii u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// digit predictor: remainders of repeated division by ten, given out most
	// significant first; conversion stops after MAX_DIGITS digits
	function automatic void predict_digits(input logic [IN_W-1:0] value);
		logic [63:0] rest;
		logic [3:0]  rems [MAX_DIGITS];
		int          n;
		digit_item_t d;
		rest = 64'(value) & VALUE_MASK;
		n = 0;
		do begin
			rems[n] = 4'(rest % RADIX);
			rest = rest / RADIX;
			n++;
		end while (rest != 0 && n < MAX_DIGITS);
		for (int k = n - 1; k >= 0; k--) begin
			d.digit_char = b2da_pkg::ASCII_ZERO + CHAR_W'(rems[k]);
			d.last_digit = (k == 0);
			digits_due.push_back(d);
		end
	endfunction

	function automatic void note_mismatch(input string what, input logic [OUT_TD_W:0] want,
			input logic [OUT_TD_W:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch %0d: %s, expected {tlast,tdata}=%h got %h",
				mismatch_count, what, want, got);
	endfunction

	// digit check on every accepted output item
	always @(posedge clk) begin
		digit_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digits_due.size() == 0) begin
				note_mismatch("digit with none expected", 'x, {m_tlast, m_tdata});
			end else begin
				want = digits_due.pop_front();
				if (m_tdata !== OUT_TD_W'(want.digit_char) || m_tlast !== want.last_digit)
					note_mismatch("wrong digit", {want.last_digit, OUT_TD_W'(want.digit_char)},
						{m_tlast, m_tdata});
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request so the
	// block fills its output register and stops taking input
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (rx_gap_left > 0) begin
			m_tready <= 1'b0;
			rx_gap_left <= rx_gap_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rx_gap_left <= $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: ends the run if nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** binary_to_decimal_ascii: FAILED **");
		$finish;
	end

	// offers one value, with an optional random gap first; returns at the
	// edge where it is taken, leaving s_tvalid high for a following item
	task automatic send_value(input logic [IN_W-1:0] value);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		predict_digits(value);
	endtask

	// random values over all digit counts, with some around powers of ten
	function automatic logic [IN_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			3:       return pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic wait_all_digits();
		s_tvalid <= 1'b0;
		while (digits_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// zero, single digits, every digit count at its top value, some powers of ten, extremes
	task automatic test_directed();
		logic [IN_W-1:0] picks [22] = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
			32'd999, 32'd1000, 32'd9999, 32'd99999, 32'd999999, 32'd9999999,
			32'd99999999, 32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, 32'd1234567890};
		foreach (picks[i]) send_value(picks[i]);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_value(pick_value());
	endtask

	// long receiver hold-off while values keep coming
	task automatic test_backpressure();
		hold_requests <= hold_requests + 1;
		repeat (10) send_value(pick_value());
	endtask

	// full-width values only
	task automatic test_random_wide(input int count);
		repeat (count) send_value($urandom);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(150);
		test_backpressure();
		test_random_wide(80);
		// last part of the run: back to back on both sides
		gaps_on = 1'b0;
		test_random_mix(70);
		wait_all_digits();
		if (mismatch_count == 0 && digits_due.size() == 0)
			$display("** binary_to_decimal_ascii: PASSED **");
		else
			$display("** binary_to_decimal_ascii: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_ctrl.sv
hw/rtl/b2da_dpath.sv
hw/rtl/binary_to_decimal_ascii.sv
test/tb_binary_to_decimal_ascii.sv
